>>> design/cce_pkg.sv
// Shared types, register codes and bit-manipulation functions of the CRC engine.
package cce_pkg;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 32;
  localparam int CRC_W       = 32;

  localparam logic [CFG_INDEX_W-1:0] REG_CRC_WIDTH      = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_GENERATOR_POLY = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_INIT_VALUE     = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_XOR_AT_START   = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_XOR_AT_END     = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_REFLECT_INPUT  = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] REG_REFLECT_OUTPUT = 3'd6;

  localparam logic [5:0] WIDTH_16 = 6'd16;
  localparam logic [5:0] WIDTH_24 = 6'd24;
  localparam logic [5:0] WIDTH_32 = 6'd32;

  localparam logic [CRC_W-1:0] MASK_16 = 32'h0000_FFFF;
  localparam logic [CRC_W-1:0] MASK_24 = 32'h00FF_FFFF;
  localparam logic [CRC_W-1:0] MASK_32 = 32'hFFFF_FFFF;

  localparam logic [CRC_W-1:0] RESET_POLY = 32'h04C1_1DB7;

  typedef struct packed {
    logic [5:0]       crc_width;
    logic [CRC_W-1:0] generator_poly;
    logic [CRC_W-1:0] init_value;
    logic [CRC_W-1:0] xor_at_start;
    logic [CRC_W-1:0] xor_at_end;
    logic             reflect_input;
    logic             reflect_output;
  } cfg_t;

  typedef struct packed {
    logic [7:0]       data_byte;
    logic             byte_present;
    logic             first_item;
    logic [CRC_W-1:0] seed;
  } item_t;

  typedef struct packed {
    logic             width_valid;
    logic [CRC_W-1:0] reg_next;
    logic [CRC_W-1:0] crc_result;
    logic             width_error;
  } step_t;

  function automatic logic [7:0] rev8(input logic [7:0] v);
    logic [7:0] r;
    for (int i = 0; i < 8; i++) r[i] = v[7-i];
    return r;
  endfunction

  function automatic logic [CRC_W-1:0] rev32(input logic [CRC_W-1:0] v);
    logic [CRC_W-1:0] r;
    for (int i = 0; i < CRC_W; i++) r[i] = v[CRC_W-1-i];
    return r;
  endfunction

  // Reverse the low w bits of v; only the supported widths matter here.
  function automatic logic [CRC_W-1:0] rev_width(input logic [CRC_W-1:0] v,
                                                 input logic [5:0] w);
    logic [CRC_W-1:0] r;
    r = rev32(v);
    case (w)
      WIDTH_16: rev_width = r >> 16;
      WIDTH_24: rev_width = r >> 8;
      default:  rev_width = r;
    endcase
  endfunction

  // Fold one byte into a reflected register with eight shift steps.
  function automatic logic [CRC_W-1:0] fold8(input logic [CRC_W-1:0] crc,
                                             input logic [7:0] b,
                                             input logic [CRC_W-1:0] rpoly);
    logic [CRC_W-1:0] r;
    r = crc ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      r = r[0] ? ((r >> 1) ^ rpoly) : (r >> 1);
    end
    return r;
  endfunction

endpackage

>>> design/cce_step.sv
// Combinational next-state and result logic for one message byte.
module cce_step (
  input  cce_pkg::cfg_t               cfg,
  input  cce_pkg::item_t              item,
  input  logic [cce_pkg::CRC_W-1:0]   crc_register,
  output cce_pkg::step_t              step
);
  import cce_pkg::*;

  logic             width_valid;
  logic [CRC_W-1:0] mask;
  logic [CRC_W-1:0] rpoly;
  logic [CRC_W-1:0] start;
  logic [CRC_W-1:0] loaded;
  logic [CRC_W-1:0] folded;
  logic [CRC_W-1:0] out_bits;
  logic [7:0]       in_byte;

  always_comb begin
    width_valid = (cfg.crc_width == WIDTH_16) || (cfg.crc_width == WIDTH_24) ||
                  (cfg.crc_width == WIDTH_32);
    case (cfg.crc_width)
      WIDTH_16: mask = MASK_16;
      WIDTH_24: mask = MASK_24;
      default:  mask = MASK_32;
    endcase

    rpoly = rev_width(cfg.generator_poly & mask, cfg.crc_width);

    // A zero seed means start from the configured init value.
    start = item.seed & mask;
    if (start == '0) start = cfg.init_value & mask;
    start = (start ^ cfg.xor_at_start) & mask;

    loaded  = item.first_item ? start : (crc_register & mask);
    in_byte = cfg.reflect_input ? item.data_byte : rev8(item.data_byte);
    folded  = item.byte_present ? (fold8(loaded, in_byte, rpoly) & mask) : loaded;

    out_bits = cfg.reflect_output ? folded : rev_width(folded, cfg.crc_width);

    step.width_valid = width_valid;
    step.reg_next    = folded;
    step.crc_result  = width_valid ? ((out_bits ^ cfg.xor_at_end) & mask) : '0;
    step.width_error = ~width_valid;
  end

endmodule

>>> design/configurable_crc_engine.sv
// Top level of the streaming configurable CRC engine.
//
// The engine computes a reflected-register CRC of width 16, 24 or 32 bits over a
// stream of message bytes, one byte per request. It takes one request every
// clock cycle while not stalled: a request is captured in an input register,
// and from there the byte is folded into the CRC register by eight unrolled
// shift-and-XOR steps with the bit-reversed polynomial, which is also what sets
// the rate, since that fold closes a loop through the CRC register. A request
// marked last produces one result, passed from the input register into a held
// output register; the input side keeps taking requests while that result waits,
// and only stalls when a further last request would need the occupied output
// register. A first request reloads the register from the seed (or from the
// init value when the seed is zero) and XORs in xor_at_start; an empty request
// (byte not present) can carry first or last alone, for empty messages. The
// reversed polynomial and width masks are derived directly from the
// configuration registers, so new settings apply to the very next request.
// Configuration must only be written while no request is in flight. An
// unsupported width leaves the CRC register untouched and a last request then
// returns a zero result with the error flag set.
module configurable_crc_engine (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [39:0]                       s_axis_tdata,  // data_byte, seed
  input  logic [1:0]                        s_axis_tuser,  // byte_present, first_item
  input  logic                              s_axis_tlast,  // last_item
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [31:0]                       m_axis_tdata,  // crc_result
  output logic [0:0]                        m_axis_tuser,  // width_error
  input  logic                              cfg_we,
  input  logic [cce_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [cce_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import cce_pkg::*;

  cfg_t             cfg;
  item_t            item;
  step_t            step;
  logic             in_valid;
  logic             in_last;
  logic [CRC_W-1:0] crc_register;
  logic             advance;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.crc_width      <= WIDTH_32;
      cfg.generator_poly <= RESET_POLY;
      cfg.init_value     <= '0;
      cfg.xor_at_start   <= '0;
      cfg.xor_at_end     <= '0;
      cfg.reflect_input  <= 1'b1;
      cfg.reflect_output <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_CRC_WIDTH:      cfg.crc_width      <= cfg_data[5:0];
        REG_GENERATOR_POLY: cfg.generator_poly <= cfg_data;
        REG_INIT_VALUE:     cfg.init_value     <= cfg_data;
        REG_XOR_AT_START:   cfg.xor_at_start   <= cfg_data;
        REG_XOR_AT_END:     cfg.xor_at_end     <= cfg_data;
        REG_REFLECT_INPUT:  cfg.reflect_input  <= cfg_data[0];
        REG_REFLECT_OUTPUT: cfg.reflect_output <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // The held request moves on unless it needs the output register and that
  // register still holds a result that has not been taken.
  assign advance       = in_valid && (!in_last || !m_axis_tvalid || m_axis_tready);
  assign s_axis_tready = !in_valid || advance;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
    if (s_axis_tvalid && s_axis_tready) begin
      item.data_byte    <= s_axis_tdata[7:0];
      item.seed         <= s_axis_tdata[39:8];
      item.byte_present <= s_axis_tuser[0];
      item.first_item   <= s_axis_tuser[1];
      in_last           <= s_axis_tlast;
    end
  end

  cce_step u_step (
    .cfg          (cfg),
    .item         (item),
    .crc_register (crc_register),
    .step         (step)
  );

  // Running CRC register.
  always_ff @(posedge clk) begin
    if (rst) begin
      crc_register <= '0;
    end else if (advance && step.width_valid) begin
      crc_register <= step.reg_next;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else begin
      m_axis_tvalid <= (advance && in_last) || (m_axis_tvalid && !m_axis_tready);
    end
    if (advance && in_last) begin
      m_axis_tdata    <= step.crc_result;
      m_axis_tuser[0] <= step.width_error;
    end
  end

endmodule
